// File: hdl/psc_pkg.sv
package psc_pkg;

    // Default sizing of the datapath
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int ACCUM_BITS_DEF     = 40;

    // Fixed field widths
    localparam int GAIN_BITS      = 16;
    localparam int DUTY_BITS      = 7;
    localparam int OUT_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;

    // Duty ceiling in whole percent
    localparam int DUTY_MAX = 100;

    // Gain reset values, unsigned Q4.12 (0.290 for the proportional term)
    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 16'd1188;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = 16'd0;
    localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RESET = 16'd0;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DERIV_GAIN = 2'd2;

    // The three loop gains as handed to the multiplier stage
    typedef struct packed {
        logic [GAIN_BITS-1:0] prop_gain;
        logic [GAIN_BITS-1:0] integ_gain;
        logic [GAIN_BITS-1:0] deriv_gain;
    } gains_t;

endpackage

// File: hdl/psc_err_stage.sv
module psc_err_stage #(
    parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
    parameter int ACCUM_BITS  = psc_pkg::ACCUM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        measured_speed,
    input  logic [SAMPLE_BITS-1:0]        target_speed,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS:0]   err,
    output logic signed [ACCUM_BITS-1:0]  acc,
    output logic signed [SAMPLE_BITS+1:0] rate
);
    import psc_pkg::*;

    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int RATE_W = SAMPLE_BITS + 2;
    localparam int WIDE_W = ((ACCUM_BITS > ERR_W) ? ACCUM_BITS : ERR_W) + 1;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [SAMPLE_BITS-1:0]  meas_reg;
    logic [SAMPLE_BITS-1:0]  targ_reg;
    logic                    err_valid_reg;
    logic                    err_valid_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic signed [ACCUM_BITS-1:0] acc_reg;
    logic signed [ACCUM_BITS-1:0] acc_next;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [RATE_W-1:0] rate_next;
    logic signed [WIDE_W-1:0] acc_wide;
    logic                    acc_in_range;
    logic                    err_ready;
    logic                    load_in;
    logic                    load_err;

    // Two register slices: the input sample, then error, accumulator and rate.
    assign err_ready = !err_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || err_ready;
    assign load_in   = in_valid && in_ready;
    assign load_err  = in_valid_reg && err_ready;

    assign in_valid_next  = load_in ? 1'b1 : (err_ready ? 1'b0 : in_valid_reg);
    assign err_valid_next = load_err ? 1'b1 : (out_ready ? 1'b0 : err_valid_reg);

    // Error of this sample and its change since the previous sample.
    // The error register doubles as the previous error state.
    always_comb
    begin
        err_next  = $signed({1'b0, targ_reg}) - $signed({1'b0, meas_reg});
        rate_next = RATE_W'(err_next) - RATE_W'(err_reg);
    end

    // Saturating accumulator update, worked one bit wider than both operands.
    always_comb
    begin
        acc_wide     = WIDE_W'(acc_reg) + WIDE_W'(err_next);
        acc_in_range = (acc_wide[WIDE_W-1:ACCUM_BITS-1] == '0) ||
                       (acc_wide[WIDE_W-1:ACCUM_BITS-1] == '1);
        if (acc_in_range)
        begin
            acc_next = acc_wide[ACCUM_BITS-1:0];
        end
        else if (acc_wide[WIDE_W-1])
        begin
            acc_next = {1'b1, {(ACCUM_BITS-1){1'b0}}};
        end
        else
        begin
            acc_next = {1'b0, {(ACCUM_BITS-1){1'b1}}};
        end
    end

    // Control and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            err_valid_reg <= 1'b0;
            err_reg       <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            err_valid_reg <= err_valid_next;
            if (load_err)
            begin
                err_reg <= err_next;
                acc_reg <= acc_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            meas_reg <= measured_speed;
            targ_reg <= target_speed;
        end
        if (load_err)
        begin
            rate_reg <= rate_next;
        end
    end

    assign out_valid = err_valid_reg;
    assign err       = err_reg;
    assign acc       = acc_reg;
    assign rate      = rate_reg;

endmodule

// File: hdl/psc_mul_stage.sv
module psc_mul_stage #(
    parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
    parameter int ACCUM_BITS  = psc_pkg::ACCUM_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  psc_pkg::gains_t                               gains,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [SAMPLE_BITS:0]                   err,
    input  logic signed [ACCUM_BITS-1:0]                  acc,
    input  logic signed [SAMPLE_BITS+1:0]                 rate,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [psc_pkg::GAIN_BITS+SAMPLE_BITS+1:0] prod_p,
    output logic signed [psc_pkg::GAIN_BITS+ACCUM_BITS:0]    prod_i,
    output logic signed [psc_pkg::GAIN_BITS+SAMPLE_BITS+2:0] prod_d
);
    import psc_pkg::*;

    localparam int P_W = GAIN_BITS + 1 + SAMPLE_BITS + 1;
    localparam int I_W = GAIN_BITS + 1 + ACCUM_BITS;
    localparam int D_W = GAIN_BITS + 1 + SAMPLE_BITS + 2;

    logic                    valid_reg;
    logic                    valid_next;
    logic                    load;
    logic signed [GAIN_BITS:0] kp;
    logic signed [GAIN_BITS:0] ki;
    logic signed [GAIN_BITS:0] kd;
    logic signed [P_W-1:0]   prod_p_reg;
    logic signed [P_W-1:0]   prod_p_next;
    logic signed [I_W-1:0]   prod_i_reg;
    logic signed [I_W-1:0]   prod_i_next;
    logic signed [D_W-1:0]   prod_d_reg;
    logic signed [D_W-1:0]   prod_d_next;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Gains are unsigned; a zero sign bit lets them enter signed multiplies.
    assign kp = $signed({1'b0, gains.prop_gain});
    assign ki = $signed({1'b0, gains.integ_gain});
    assign kd = $signed({1'b0, gains.deriv_gain});

    // Three independent multiplies, each registered on its own.
    always_comb
    begin
        prod_p_next = P_W'(kp) * P_W'(err);
        prod_i_next = I_W'(ki) * I_W'(acc);
        prod_d_next = D_W'(kd) * D_W'(rate);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod_p    = prod_p_reg;
    assign prod_i    = prod_i_reg;
    assign prod_d    = prod_d_reg;

endmodule

// File: hdl/psc_sum_stage.sv
module psc_sum_stage #(
    parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
    parameter int ACCUM_BITS  = psc_pkg::ACCUM_BITS_DEF,
    parameter int SUM_W       = 64
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic signed [psc_pkg::GAIN_BITS+SAMPLE_BITS+1:0] prod_p,
    input  logic signed [psc_pkg::GAIN_BITS+ACCUM_BITS:0]    prod_i,
    input  logic signed [psc_pkg::GAIN_BITS+SAMPLE_BITS+2:0] prod_d,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic signed [SUM_W-1:0]                          neg_sum
);
    import psc_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic                   load;
    logic signed [SUM_W-1:0] neg_sum_reg;
    logic signed [SUM_W-1:0] neg_sum_next;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Negated control sum, wide enough that neither the sum nor its negation overflows.
    assign neg_sum_next = -SUM_W'(prod_p) - SUM_W'(prod_i) - SUM_W'(prod_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_sum_reg <= neg_sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign neg_sum   = neg_sum_reg;

endmodule

// File: hdl/psc_duty_stage.sv
module psc_duty_stage #(
    parameter int GAIN_FRAC_BITS = psc_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SUM_W          = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SUM_W-1:0]           neg_sum,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psc_pkg::DUTY_BITS-1:0]     duty_percent
);
    import psc_pkg::*;

    localparam int Q_W = SUM_W - GAIN_FRAC_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    logic                 load;
    logic [Q_W-1:0]       whole;
    logic [DUTY_BITS-1:0] duty_reg;
    logic [DUTY_BITS-1:0] duty_next;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Drop the fraction bits; for a positive value this truncates toward zero.
    assign whole = neg_sum[SUM_W-1:GAIN_FRAC_BITS];

    // A negative control gives no drive, a large one is held at full duty.
    always_comb
    begin
        if (neg_sum[SUM_W-1])
        begin
            duty_next = '0;
        end
        else if (whole > Q_W'(DUTY_MAX))
        begin
            duty_next = DUTY_BITS'(DUTY_MAX);
        end
        else
        begin
            duty_next = whole[DUTY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid    = valid_reg;
    assign duty_percent = duty_reg;

endmodule

// File: hdl/pid_speed_controller_top.sv
// PID speed controller: turns a stream of speed samples into PWM duty values.
// Each request on the slave side carries a measured speed and a target speed;
// each request on the master side carries one duty value, 0 to 100 percent.
// Every input sample gives exactly one duty value, in order.
// The gains are set through the configuration channel (index 0 proportional,
// 1 integral, 2 derivative, unsigned Q4.12); other indexes are ignored.
// cfg_ready is always high. Gains should only change while the stream is idle.
// A result passes through the input, error, product, sum and output registers
// before it is presented. Throughput: one sample per cycle while m_tready
// stays high. The error accumulator and the previous error are updated
// together as each sample moves from the input into the error register.
// Reset clears every stage, the accumulator and the previous error, and loads
// the reset gains (proportional 0.290, the others zero).
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps filling; s_tready falls once all stages hold a result.
module pid_speed_controller_top #(
    parameter int SAMPLE_BITS    = psc_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = psc_pkg::GAIN_FRAC_BITS_DEF,
    parameter int ACCUM_BITS     = psc_pkg::ACCUM_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // measured_speed, target_speed (low bits up), zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // duty_percent in bits 6:0, bit 7 zero
    output logic [psc_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [psc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [psc_pkg::GAIN_BITS-1:0]          cfg_data
);
    import psc_pkg::*;

    localparam int RATE_W = SAMPLE_BITS + 2;
    localparam int P_MAX  = GAIN_BITS + 1 + ((ACCUM_BITS > RATE_W) ? ACCUM_BITS : RATE_W);
    localparam int SUM_W  = P_MAX + 2;

    gains_t gains_reg;
    gains_t gains_next;

    logic                                   err_valid;
    logic                                   err_ready;
    logic signed [SAMPLE_BITS:0]            err;
    logic signed [ACCUM_BITS-1:0]           acc;
    logic signed [SAMPLE_BITS+1:0]          rate;
    logic                                   mul_valid;
    logic                                   mul_ready;
    logic signed [GAIN_BITS+SAMPLE_BITS+1:0] prod_p;
    logic signed [GAIN_BITS+ACCUM_BITS:0]    prod_i;
    logic signed [GAIN_BITS+SAMPLE_BITS+2:0] prod_d;
    logic                                   sum_valid;
    logic                                   sum_ready;
    logic signed [SUM_W-1:0]                neg_sum;
    logic [DUTY_BITS-1:0]                   duty_percent;

    // Gain registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:  gains_next.prop_gain  = cfg_data;
                CFG_INTEG_GAIN: gains_next.integ_gain = cfg_data;
                CFG_DERIV_GAIN: gains_next.deriv_gain = cfg_data;
                default:        gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain  <= PROP_GAIN_RESET;
            gains_reg.integ_gain <= INTEG_GAIN_RESET;
            gains_reg.deriv_gain <= DERIV_GAIN_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    // Sample register, error, accumulator and rate.
    psc_err_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACCUM_BITS  (ACCUM_BITS)
    ) u_err (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .measured_speed (s_tdata[SAMPLE_BITS-1:0]),
        .target_speed   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .out_valid      (err_valid),
        .out_ready      (err_ready),
        .err            (err),
        .acc            (acc),
        .rate           (rate)
    );

    // Gain products.
    psc_mul_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACCUM_BITS  (ACCUM_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .err       (err),
        .acc       (acc),
        .rate      (rate),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod_p    (prod_p),
        .prod_i    (prod_i),
        .prod_d    (prod_d)
    );

    // Negated sum of the three terms.
    psc_sum_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACCUM_BITS  (ACCUM_BITS),
        .SUM_W       (SUM_W)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod_p    (prod_p),
        .prod_i    (prod_i),
        .prod_d    (prod_d),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .neg_sum   (neg_sum)
    );

    // Clamp to a whole duty percentage and hold it for the receiver.
    psc_duty_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_W          (SUM_W)
    ) u_duty (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sum_valid),
        .in_ready     (sum_ready),
        .neg_sum      (neg_sum),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .duty_percent (duty_percent)
    );

    assign m_tdata = OUT_DATA_BITS'(duty_percent);

endmodule
